// ----- rtl/lfsa_pkg.sv -----
// shared constants, codes and types for the lowest free slot allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfsa_pkg;

  // pool geometry
  localparam int SLOTS   = 1024;
  localparam int SLOT_W  = 10;
  localparam int CNT_W   = 11;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = SLOTS / WORD_W;
  localparam int WIDX_W  = $clog2(WORDS);

  // field widths
  localparam int KIND_W     = 2;
  localparam int CLASS_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 11;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC_LOW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC_AT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_STATE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MISC_CAP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISC_MASK = 1'd1;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd300;
  localparam logic [MASK_W-1:0] MASK_RESET = 16'd8176;
  localparam logic [CNT_W-1:0]  FREE_RESET = CNT_W'(SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted;
    logic [CNT_W-1:0]    free_cnt;
    logic [CNT_W-1:0]    misc_cnt;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/lfsa_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lfsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/lfsa_prio_enc.sv -----
// shared lowest-set-bit encoder, used on the word summary and on one map word
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lfsa_prio_enc #(
  parameter int W  = 32,
  parameter int IW = $clog2(W)
) (
  input  wire logic [W-1:0]  vec_i,
  output logic      [IW-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lowest_free_slot_allocator.sv -----
// lowest free slot allocator: sequencer, counters, free map and effect flag rams
// depends on lfsa_pkg, lfsa_ram, lfsa_prio_enc
// steps: decide, map access, result (done); no free slot, effect limit or unused kind
// end in the decide step and skip the map access
// a new item is taken only while the sequencer is idle, so items do not overlap;
// the next item is taken while a result waits, a stalled result holds the sequencer in done
// reset: all slots free through per-word valid bits (no clearing pass), free count 1024,
// effect count 0, cap 300, class mask 0x1ff0
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_slot_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lfsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lfsa_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [lfsa_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [lfsa_pkg::CLASS_W-1:0]      entity_class_i,
  input  wire logic [lfsa_pkg::SLOT_W-1:0]       slot_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [lfsa_pkg::STATUS_W-1:0]     status_o,
  output logic      [lfsa_pkg::SLOT_W-1:0]       granted_slot_o,
  output logic      [lfsa_pkg::CNT_W-1:0]        free_count_o,
  output logic      [lfsa_pkg::CNT_W-1:0]        misc_count_o
);

  localparam int WORD_W = lfsa_pkg::WORD_W;
  localparam int WORDS  = lfsa_pkg::WORDS;
  localparam int WIDX_W = lfsa_pkg::WIDX_W;
  localparam int BIT_W  = lfsa_pkg::BIT_W;
  localparam int SLOT_W = lfsa_pkg::SLOT_W;
  localparam int CNT_W  = lfsa_pkg::CNT_W;

  lfsa_pkg::state_e state_q, state_d;

  logic [lfsa_pkg::CAP_W-1:0]   cap_q;
  logic [lfsa_pkg::MASK_W-1:0]  mask_q;
  logic [CNT_W-1:0]             free_q, free_d;
  logic [CNT_W-1:0]             misc_q, misc_d;
  logic [WORDS-1:0]             has_free_q, has_free_d;
  logic [WORDS-1:0]             touched_q, touched_d;

  logic [lfsa_pkg::KIND_W-1:0]  kind_q;
  logic [lfsa_pkg::CLASS_W-1:0] cls_q;
  logic [SLOT_W-1:0]            idx_q;
  logic [WIDX_W-1:0]            word_q, word_d;

  lfsa_pkg::result_t            res_q, res_d;
  lfsa_pkg::result_t            out_q;
  logic                         out_valid_q, out_valid_d;

  logic                         in_beat;
  logic                         out_free;
  logic                         eff_cls;
  logic                         limit;
  logic                         in_range;
  logic [WORD_W-1:0]            enc_vec;
  logic [BIT_W-1:0]             enc_idx;
  logic [WORD_W-1:0]            fm_rdata;
  logic [WORD_W-1:0]            word_data;
  logic [WORD_W-1:0]            new_word;
  logic [BIT_W-1:0]             bit_sel;
  logic                         bit_free;
  logic                         hit;
  logic                         release_op;
  logic                         fm_re, fm_we;
  logic [WIDX_W-1:0]            fm_raddr;
  logic                         eff_we, eff_re;
  logic [0:0]                   eff_rdata;
  logic [SLOT_W-1:0]            slot_sel;

  assign in_stall_o = (state_q != lfsa_pkg::ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign eff_cls    = mask_q[cls_q];
  assign limit      = eff_cls && ((misc_q > cap_q) || ((cap_q - misc_q) >= free_q));
  assign in_range   = (CNT_W'(idx_q) < CNT_W'(lfsa_pkg::SLOTS));
  assign release_op = (kind_q == lfsa_pkg::KIND_RELEASE);

  // untouched words read as all free
  assign word_data = touched_q[word_q] ? fm_rdata : '1;

  // shared encoder: word summary while deciding, map word while accessing
  assign enc_vec = (state_q == lfsa_pkg::ST_DECIDE) ? WORD_W'(has_free_q) : word_data;

  lfsa_prio_enc #(
    .W (WORD_W)
  ) u_enc (
    .vec_i (enc_vec),
    .idx_o (enc_idx)
  );

  assign bit_sel  = (kind_q == lfsa_pkg::KIND_ALLOC_LOW) ? enc_idx : idx_q[BIT_W-1:0];
  assign bit_free = word_data[bit_sel];
  assign slot_sel = {word_q, bit_sel};

  always_comb begin
    new_word          = word_data;
    new_word[bit_sel] = release_op;
  end

  always_comb begin
    unique case (kind_q)
      lfsa_pkg::KIND_ALLOC_LOW: hit = 1'b1;
      lfsa_pkg::KIND_ALLOC_AT:  hit = bit_free;
      lfsa_pkg::KIND_RELEASE:   hit = !bit_free;
      default:                  hit = 1'b0;
    endcase
  end

  assign fm_raddr = (kind_q == lfsa_pkg::KIND_ALLOC_LOW) ? enc_idx[WIDX_W-1:0]
                                                         : idx_q[SLOT_W-1:BIT_W];
  assign fm_re    = (state_q == lfsa_pkg::ST_DECIDE);
  assign fm_we    = (state_q == lfsa_pkg::ST_ACCESS) && hit;
  assign eff_re   = (state_q == lfsa_pkg::ST_DECIDE);
  assign eff_we   = fm_we && !release_op;

  lfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_free_map (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (word_q),
    .wdata_i (new_word),
    .re_i    (fm_re),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata)
  );

  lfsa_ram #(
    .WIDTH (1),
    .DEPTH (lfsa_pkg::SLOTS)
  ) u_effect (
    .clk_i   (clk_i),
    .we_i    (eff_we),
    .waddr_i (slot_sel),
    .wdata_i (eff_cls),
    .re_i    (eff_re),
    .raddr_i (idx_q),
    .rdata_o (eff_rdata)
  );

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    misc_d      = misc_q;
    has_free_d  = has_free_q;
    touched_d   = touched_q;
    word_d      = word_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      lfsa_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_d = lfsa_pkg::ST_DECIDE;
        end
      end
      lfsa_pkg::ST_DECIDE: begin
        word_d         = fm_raddr;
        res_d.granted  = '0;
        res_d.free_cnt = free_q;
        res_d.misc_cnt = misc_q;
        state_d        = lfsa_pkg::ST_DONE;
        case (kind_q)
          lfsa_pkg::KIND_ALLOC_LOW: begin
            if (free_q == '0) begin
              res_d.status = lfsa_pkg::STATUS_NO_FREE;
            end else if (limit) begin
              res_d.status = lfsa_pkg::STATUS_LIMIT;
            end else begin
              state_d = lfsa_pkg::ST_ACCESS;
            end
          end
          lfsa_pkg::KIND_ALLOC_AT, lfsa_pkg::KIND_RELEASE: begin
            res_d.status = lfsa_pkg::STATUS_BAD_STATE;
            if (in_range) begin
              state_d = lfsa_pkg::ST_ACCESS;
            end
          end
          default: begin
            res_d.status = lfsa_pkg::STATUS_BAD_STATE;
          end
        endcase
      end
      lfsa_pkg::ST_ACCESS: begin
        state_d = lfsa_pkg::ST_DONE;
        if (hit) begin
          touched_d[word_q]  = 1'b1;
          has_free_d[word_q] = |new_word;
          if (release_op) begin
            free_d = free_q + CNT_W'(1);
            if (eff_rdata[0] && (misc_q != '0)) begin
              misc_d = misc_q - CNT_W'(1);
            end
          end else begin
            free_d = free_q - CNT_W'(1);
            misc_d = misc_q + CNT_W'(eff_cls);
          end
          res_d.status   = lfsa_pkg::STATUS_OK;
          res_d.granted  = slot_sel;
          res_d.free_cnt = free_d;
          res_d.misc_cnt = misc_d;
        end else begin
          res_d.status   = lfsa_pkg::STATUS_BAD_STATE;
          res_d.granted  = '0;
          res_d.free_cnt = free_q;
          res_d.misc_cnt = misc_q;
        end
      end
      lfsa_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = lfsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfsa_pkg::ST_IDLE;
      cap_q       <= lfsa_pkg::CAP_RESET;
      mask_q      <= lfsa_pkg::MASK_RESET;
      free_q      <= lfsa_pkg::FREE_RESET;
      misc_q      <= '0;
      has_free_q  <= '1;
      touched_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      misc_q      <= misc_d;
      has_free_q  <= has_free_d;
      touched_q   <= touched_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lfsa_pkg::CFG_MISC_CAP:  cap_q  <= cfg_wdata_i[lfsa_pkg::CAP_W-1:0];
          lfsa_pkg::CFG_MISC_MASK: mask_q <= cfg_wdata_i[lfsa_pkg::MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      kind_q <= kind_i;
      cls_q  <= entity_class_i;
      idx_q  <= slot_index_i;
    end
    word_q <= word_d;
    res_q  <= res_d;
    if ((state_q == lfsa_pkg::ST_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign granted_slot_o = out_q.granted;
  assign free_count_o   = out_q.free_cnt;
  assign misc_count_o   = out_q.misc_cnt;

endmodule

`default_nettype wire

// ----- dv/tb_lowest_free_slot_allocator.sv -----
// self-checking bench for lowest_free_slot_allocator: directed table, then random
// traffic under several register settings and idle/stall patterns
// depends on lfsa_pkg and the rtl of lowest_free_slot_allocator
`timescale 1ns / 1ps

module tb_lowest_free_slot_allocator;
  import lfsa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 220;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [CLASS_W-1:0]  cls;
    logic [SLOT_W-1:0]   idx;
    bit                  typed;
    logic [STATUS_W-1:0] st;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    free;
    logic [CNT_W-1:0]    misc;
  } dir_row_t;

  localparam int NUM_DIR = 22;

  // rows run from reset, cap 300, effect classes 4 to 12
  dir_row_t dir_rows [NUM_DIR] = '{
    '{KIND_RELEASE,   4'd0,  10'd0,    1'b1, STATUS_BAD_STATE, 10'd0,    11'd1024, 11'd0},
    '{KIND_RELEASE,   4'd15, 10'd1023, 1'b1, STATUS_BAD_STATE, 10'd0,    11'd1024, 11'd0},
    '{KIND_UNUSED,    4'd15, 10'd1023, 1'b1, STATUS_BAD_STATE, 10'd0,    11'd1024, 11'd0},
    '{KIND_ALLOC_AT,  4'd15, 10'd1023, 1'b1, STATUS_OK,        10'd1023, 11'd1023, 11'd0},
    '{KIND_ALLOC_LOW, 4'd0,  10'd1023, 1'b1, STATUS_OK,        10'd0,    11'd1022, 11'd0},
    '{KIND_ALLOC_LOW, 4'd4,  10'd0,    1'b1, STATUS_OK,        10'd1,    11'd1021, 11'd1},
    '{KIND_ALLOC_LOW, 4'd12, 10'd0,    1'b1, STATUS_OK,        10'd2,    11'd1020, 11'd2},
    '{KIND_ALLOC_LOW, 4'd13, 10'd0,    1'b1, STATUS_OK,        10'd3,    11'd1019, 11'd2},
    '{KIND_ALLOC_AT,  4'd0,  10'd1023, 1'b1, STATUS_BAD_STATE, 10'd0,    11'd1019, 11'd2},
    '{KIND_ALLOC_AT,  4'd4,  10'd0,    1'b1, STATUS_BAD_STATE, 10'd0,    11'd1019, 11'd2},
    '{KIND_RELEASE,   4'd0,  10'd1,    1'b1, STATUS_OK,        10'd1,    11'd1020, 11'd1},
    '{KIND_RELEASE,   4'd0,  10'd1,    1'b1, STATUS_BAD_STATE, 10'd0,    11'd1020, 11'd1},
    '{KIND_ALLOC_LOW, 4'd3,  10'd0,    1'b1, STATUS_OK,        10'd1,    11'd1019, 11'd1},
    '{KIND_ALLOC_AT,  4'd8,  10'd512,  1'b1, STATUS_OK,        10'd512,  11'd1018, 11'd2},
    '{KIND_ALLOC_AT,  4'd7,  10'd4,    1'b1, STATUS_OK,        10'd4,    11'd1017, 11'd3},
    '{KIND_ALLOC_LOW, 4'd11, 10'd0,    1'b1, STATUS_OK,        10'd5,    11'd1016, 11'd4},
    '{KIND_RELEASE,   4'd0,  10'd2,    1'b1, STATUS_OK,        10'd2,    11'd1017, 11'd3},
    '{KIND_ALLOC_LOW, 4'd1,  10'd0,    1'b0, STATUS_OK,        10'd0,    11'd0,    11'd0},
    '{KIND_RELEASE,   4'd9,  10'd512,  1'b0, STATUS_OK,        10'd0,    11'd0,    11'd0},
    '{KIND_RELEASE,   4'd0,  10'd1023, 1'b1, STATUS_OK,        10'd1023, 11'd1018, 11'd2},
    '{KIND_UNUSED,    4'd0,  10'd0,    1'b1, STATUS_BAD_STATE, 10'd0,    11'd1018, 11'd2},
    '{KIND_ALLOC_LOW, 4'd15, 10'd0,    1'b0, STATUS_OK,        10'd0,    11'd0,    11'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i = '0;
  logic [CLASS_W-1:0]    entity_class_i = '0;
  logic [SLOT_W-1:0]     slot_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_W-1:0]     granted_slot_o;
  logic [CNT_W-1:0]      free_count_o;
  logic [CNT_W-1:0]      misc_count_o;

  // allocator state as predicted
  bit             slot_free [SLOTS] = '{default: 1'b1};
  bit             slot_is_effect [SLOTS] = '{default: 1'b0};
  int             free_total = SLOTS;
  int             misc_total = 0;
  logic [CAP_W-1:0]  misc_cap = CAP_RESET;
  logic [MASK_W-1:0] effect_mask = MASK_RESET;

  result_t        expected_results [$];
  result_t        head_result;
  int unsigned    mismatch_count = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             quiet_cycles = 0;

  lowest_free_slot_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .entity_class_i (entity_class_i),
    .slot_index_i   (slot_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .free_count_o   (free_count_o),
    .misc_count_o   (misc_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void claim_slot(input int s, input logic [CLASS_W-1:0] cls);
    slot_free[s] = 1'b0;
    slot_is_effect[s] = effect_mask[cls];
    free_total--;
    if (effect_mask[cls]) misc_total++;
  endfunction

  function automatic result_t predict_slot_op(input logic [KIND_W-1:0] kind,
                                              input logic [CLASS_W-1:0] cls,
                                              input logic [SLOT_W-1:0] idx);
    result_t r;
    int s;
    int cap;
    r.status = STATUS_BAD_STATE;
    r.granted = '0;
    cap = int'(misc_cap);
    case (kind)
      KIND_ALLOC_LOW: begin
        if (free_total == 0) begin
          r.status = STATUS_NO_FREE;
        end else if (effect_mask[cls] &&
                     (misc_total > cap || cap - misc_total >= free_total)) begin
          r.status = STATUS_LIMIT;
        end else begin
          s = 0;
          while (!slot_free[s]) s++;
          claim_slot(s, cls);
          r.status = STATUS_OK;
          r.granted = SLOT_W'(s);
        end
      end
      KIND_ALLOC_AT: begin
        if (slot_free[idx]) begin
          claim_slot(int'(idx), cls);
          r.status = STATUS_OK;
          r.granted = idx;
        end
      end
      KIND_RELEASE: begin
        if (!slot_free[idx]) begin
          slot_free[idx] = 1'b1;
          free_total++;
          if (slot_is_effect[idx] && misc_total > 0) misc_total--;
          slot_is_effect[idx] = 1'b0;
          r.status = STATUS_OK;
          r.granted = idx;
        end
      end
      default: begin
      end
    endcase
    r.free_cnt = CNT_W'(free_total);
    r.misc_cnt = CNT_W'(misc_total);
    return r;
  endfunction

  // first slot from start on (wrapping) whose free bit equals want_free
  function automatic logic [SLOT_W-1:0] find_slot(input bit want_free, input int start);
    int k;
    for (k = 0; k < SLOTS; k++) begin
      if (slot_free[(start + k) % SLOTS] == want_free) return SLOT_W'((start + k) % SLOTS);
    end
    return SLOT_W'(start);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CLASS_W-1:0] cls,
                           input logic [SLOT_W-1:0] idx, input bit typed,
                           input result_t typed_res);
    int gap;
    result_t predicted;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    entity_class_i <= cls;
    slot_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = predict_slot_op(kind, cls, idx);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send_random_item(input int release_pct);
    int roll;
    logic [KIND_W-1:0] kind;
    logic [CLASS_W-1:0] cls;
    logic [SLOT_W-1:0] idx;
    roll = $urandom_range(0, 99);
    cls = CLASS_W'($urandom_range(0, 15));
    idx = SLOT_W'($urandom_range(0, SLOTS - 1));
    if (roll < 4) begin
      kind = KIND_UNUSED;
    end else if (roll < 4 + release_pct) begin
      kind = KIND_RELEASE;
      if ($urandom_range(0, 99) < 85) idx = find_slot(1'b0, int'(idx));
    end else if ($urandom_range(0, 99) < 20) begin
      kind = KIND_ALLOC_AT;
      if ($urandom_range(0, 99) < 80) idx = find_slot(1'b1, int'(idx));
    end else begin
      kind = KIND_ALLOC_LOW;
    end
    send_item(kind, cls, idx, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MISC_CAP) misc_cap = CAP_W'(data);
    else effect_mask = MASK_W'(data);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic start_phase(input int send_pct, input int recv_pct, input int cap,
                             input int mask);
    drain_results();
    write_reg(CFG_MISC_CAP, cap);
    write_reg(CFG_MISC_MASK, mask);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d slot %0d", status_o,
               granted_slot_o);
        mismatch_count++;
      end else begin
        head_result = expected_results.pop_front();
        if (status_o !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, status_o);
          mismatch_count++;
        end
        if (granted_slot_o !== head_result.granted) begin
          $error("granted_slot: expected %0d, got %0d", head_result.granted, granted_slot_o);
          mismatch_count++;
        end
        if (free_count_o !== head_result.free_cnt) begin
          $error("free_count: expected %0d, got %0d", head_result.free_cnt, free_count_o);
          mismatch_count++;
        end
        if (misc_count_o !== head_result.misc_cnt) begin
          $error("misc_count: expected %0d, got %0d", head_result.misc_cnt, misc_count_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("lowest_free_slot_allocator verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].cls, dir_rows[i].idx, dir_rows[i].typed,
                {dir_rows[i].st, dir_rows[i].slot, dir_rows[i].free, dir_rows[i].misc});
    end

    start_phase(0, 0, 0, 16'hFFFF);
    repeat (RANDOM_PER_PHASE) send_random_item(45);

    start_phase(0, 74, SLOTS, int'($urandom_range(0, 65535)));
    repeat (RANDOM_PER_PHASE) send_random_item(25);

    start_phase(17, 17, int'($urandom_range(900, SLOTS)), int'(MASK_RESET));
    repeat (RANDOM_PER_PHASE) send_random_item(25);

    start_phase(74, 0, int'($urandom_range(0, 20)), int'($urandom_range(0, 65535)));
    repeat (RANDOM_PER_PHASE) send_random_item(35);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("lowest_free_slot_allocator verification clean");
    else
      $display("lowest_free_slot_allocator verification failed");
    $finish;
  end

endmodule
